// ----- design/tepm_pkg.sv -----
// Shared types and status codes for the trace event pair matcher.
`timescale 1ns / 1ps
package tepm_pkg;

  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_PAIR   = 3'd1;
  localparam logic [2:0] ST_ACCUM  = 3'd2;
  localparam logic [2:0] ST_DUP    = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_ZERO   = 3'd5;
  localparam logic [2:0] ST_RECORD = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  typedef struct packed {
    logic load_in;
    logic zero_res;
    logic clr_step;
    logic scan_step;
    logic decide;
    logic stat_wr;
    logic drain_step;
    logic drain_rd;
    logic drain_wr;
    logic out_load;
  } tepm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_drain;
    logic is_zero;
    logic scan_done;
    logic need_stats;
    logic drain_done;
    logic drain_hit;
    logic out_free;
  } tepm_stat_t;

endpackage

// ----- design/tepm_ram.sv -----
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module tepm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/tepm_ctrl.sv -----
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps
module tepm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tepm_pkg::tepm_stat_t st,
  output tepm_pkg::tepm_cmd_t  cmd
);
  import tepm_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR      = 11'b00000000001,
    S_IDLE       = 11'b00000000010,
    S_DISPATCH   = 11'b00000000100,
    S_SCAN       = 11'b00000001000,
    S_DECIDE     = 11'b00000010000,
    S_STAT_RD    = 11'b00000100000,
    S_STAT_WR    = 11'b00001000000,
    S_DRAIN_SRCH = 11'b00010000000,
    S_DRAIN_RD   = 11'b00100000000,
    S_DRAIN_WR   = 11'b01000000000,
    S_FINISH     = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.is_drain) begin
          state_next = S_DRAIN_SRCH;
        end else if (st.is_zero) begin
          cmd.zero_res = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = st.need_stats ? S_STAT_RD : S_FINISH;
      end
      S_STAT_RD: begin
        state_next = S_STAT_WR;
      end
      S_STAT_WR: begin
        cmd.stat_wr = 1'b1;
        state_next  = S_FINISH;
      end
      S_DRAIN_SRCH: begin
        cmd.drain_step = 1'b1;
        if (st.drain_done) begin
          state_next = S_FINISH;
        end else if (st.drain_hit) begin
          state_next = S_DRAIN_RD;
        end
      end
      S_DRAIN_RD: begin
        cmd.drain_rd = 1'b1;
        state_next   = S_DRAIN_WR;
      end
      S_DRAIN_WR: begin
        cmd.drain_wr = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Only one transaction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!in_ready && !cmd.load_in))
    else $error("input accepted during the clearing pass");

endmodule

// ----- design/tepm_dp.sv -----
// Datapath: pending table, per-type statistics, drain cursor and result registers.
`timescale 1ns / 1ps
module tepm_dp #(
  parameter int PENDING_DEPTH = 256,
  parameter int NUM_TYPES     = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tepm_pkg::tepm_cmd_t  cmd,
  output tepm_pkg::tepm_stat_t st,
  input  logic                 stats_mode_wr_en,
  input  logic                 stats_mode_wr_data,
  input  logic                 func,
  input  logic [63:0]          event_word,
  input  logic [63:0]          timestamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [31:0]          pair_id,
  output logic [7:0]           type_id,
  output logic [15:0]          extra_info,
  output logic [63:0]          t_start,
  output logic [63:0]          t_end,
  output logic [31:0]          event_count,
  output logic [63:0]          dur_total
);
  import tepm_pkg::*;

  localparam int PW  = $clog2(PENDING_DEPTH);
  localparam int TW  = $clog2(NUM_TYPES);
  localparam int CW  = TW + 1;
  localparam int PEW = 98;
  localparam int SW  = 96;

  logic        stats_mode;
  logic        func_r;
  logic [63:0] word_r;
  logic [63:0] ts_r;

  logic [31:0] id;
  logic [7:0]  typ;
  logic [15:0] extra;
  logic        started;

  assign id      = word_r[31:0];
  assign typ     = word_r[63:56];
  assign extra   = word_r[47:32];
  assign started = |word_r[55:48];

  // Pending table scan.
  logic [PW:0]   iss;
  logic          chk_v;
  logic [PW-1:0] chk_idx;
  logic          hit;
  logic          have_free;
  logic [PW-1:0] free_slot;
  logic [PW-1:0] m_idx;
  logic [63:0]   m_time;
  logic          m_is_end;
  logic [PW-1:0] clr_idx;

  logic           p_we;
  logic [PW-1:0]  p_waddr;
  logic [PEW-1:0] p_wdata;
  logic [PEW-1:0] p_rdata;
  logic           e_valid;
  logic           e_end;
  logic [31:0]    e_key;
  logic [63:0]    e_time;
  logic           match;
  logic           last;
  logic           pair_ok;

  assign e_valid = p_rdata[97];
  assign e_end   = p_rdata[96];
  assign e_key   = p_rdata[95:64];
  assign e_time  = p_rdata[63:0];
  assign match   = chk_v && e_valid && (e_key == id);
  assign last    = chk_idx == PW'(PENDING_DEPTH - 1);
  assign pair_ok = hit && (m_is_end == started);

  assign p_we    = cmd.clr_step || (cmd.decide && (pair_ok || (!hit && have_free)));
  assign p_waddr = cmd.clr_step ? clr_idx : (hit ? m_idx : free_slot);
  assign p_wdata = cmd.clr_step ? '0 :
                   (hit ? '0 : {1'b1, !started, id, ts_r});

  tepm_ram #(.WIDTH(PEW), .DEPTH(PENDING_DEPTH)) u_pend (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(iss[PW-1:0]),
    .rdata(p_rdata)
  );

  // Result staging.
  logic [2:0]  res_status;
  logic [31:0] res_uid;
  logic [7:0]  res_type;
  logic [15:0] res_extra;
  logic [63:0] res_st;
  logic [63:0] res_en;
  logic [31:0] res_cnt;
  logic [63:0] res_tot;

  // Statistics.
  logic [NUM_TYPES-1:0] touched;
  logic [CW-1:0]        cursor;
  logic [63:0]          min_seen;
  logic [63:0]          max_seen;
  logic [31:0]          rec_id;
  logic [63:0]          dur;
  logic [TW-1:0]        t_idx;
  logic                 s_we;
  logic [SW-1:0]        s_rdata;
  logic [31:0]          cur_cnt;
  logic [63:0]          cur_tot;
  logic [31:0]          new_cnt;
  logic [63:0]          new_tot;
  logic [63:0]          st_sel;
  logic [63:0]          en_sel;
  logic [63:0]          min_a;
  logic [63:0]          max_a;
  logic                 drain_done;

  // Types beyond the table fold into the last type.
  assign t_idx = ({1'b0, typ} >= 9'(NUM_TYPES)) ? TW'(NUM_TYPES - 1) : typ[TW-1:0];
  assign s_we  = cmd.stat_wr;

  tepm_ram #(.WIDTH(SW), .DEPTH(NUM_TYPES)) u_stats (
    .clk  (clk),
    .we   (s_we),
    .waddr(t_idx),
    .wdata({new_cnt, new_tot}),
    .raddr(cmd.drain_rd ? cursor[TW-1:0] : t_idx),
    .rdata(s_rdata)
  );

  // An untouched type reads as zero, so drained entries need no rewrite.
  assign cur_cnt = touched[t_idx] ? s_rdata[95:64] : 32'd0;
  assign cur_tot = touched[t_idx] ? s_rdata[63:0] : 64'd0;
  assign new_cnt = (cur_cnt == 32'hFFFF_FFFF) ? cur_cnt : cur_cnt + 32'd1;
  assign new_tot = cur_tot + dur;

  assign st_sel = started ? ts_r : m_time;
  assign en_sel = started ? m_time : ts_r;
  assign min_a  = (res_st < res_en) ? res_st : res_en;
  assign max_a  = (res_st > res_en) ? res_st : res_en;

  assign drain_done = cursor >= CW'(NUM_TYPES);

  assign st.clr_done   = clr_idx == PW'(PENDING_DEPTH - 1);
  assign st.is_drain   = func_r;
  assign st.is_zero    = (word_r == 64'd0);
  assign st.scan_done  = chk_v && (match || last);
  assign st.need_stats = pair_ok && stats_mode;
  assign st.drain_done = drain_done;
  assign st.drain_hit  = !drain_done && touched[cursor[TW-1:0]];
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_mode <= 1'b0;
    end else if (stats_mode_wr_en) begin
      stats_mode <= stats_mode_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= func;
      word_r <= event_word;
      ts_r   <= timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss       <= '0;
      chk_v     <= 1'b0;
      hit       <= 1'b0;
      have_free <= 1'b0;
    end else if (cmd.load_in) begin
      iss       <= '0;
      chk_v     <= 1'b0;
      hit       <= 1'b0;
      have_free <= 1'b0;
    end else if (cmd.scan_step) begin
      if (iss < (PW+1)'(PENDING_DEPTH)) begin
        iss     <= iss + (PW+1)'(1);
        chk_v   <= 1'b1;
        chk_idx <= iss[PW-1:0];
      end else begin
        chk_v <= 1'b0;
      end
      if (match) begin
        hit      <= 1'b1;
        m_idx    <= chk_idx;
        m_time   <= e_time;
        m_is_end <= e_end;
      end
      if (chk_v && !e_valid && !have_free) begin
        have_free <= 1'b1;
        free_slot <= chk_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched  <= '0;
      cursor   <= '0;
      min_seen <= '1;
      max_seen <= '0;
      rec_id   <= 32'd1;
    end else begin
      if (cmd.stat_wr) begin
        touched[t_idx] <= 1'b1;
        if (min_a < min_seen) min_seen <= min_a;
        if (max_a > max_seen) max_seen <= max_a;
      end
      if (cmd.drain_step) begin
        if (drain_done) begin
          min_seen <= '1;
          max_seen <= '0;
          cursor   <= '0;
        end else if (!touched[cursor[TW-1:0]]) begin
          cursor <= cursor + CW'(1);
        end
      end
      if (cmd.drain_wr) begin
        touched[cursor[TW-1:0]] <= 1'b0;
        rec_id <= rec_id + 32'd1;
        cursor <= cursor + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_res) begin
      res_status <= ST_ZERO;
      res_uid    <= '0;
      res_type   <= '0;
      res_extra  <= '0;
      res_st     <= '0;
      res_en     <= '0;
      res_cnt    <= '0;
      res_tot    <= '0;
    end
    if (cmd.decide) begin
      res_uid   <= id;
      res_type  <= typ;
      res_extra <= extra;
      res_cnt   <= '0;
      res_tot   <= '0;
      if (pair_ok) begin
        res_status <= stats_mode ? ST_ACCUM : ST_PAIR;
        res_st     <= st_sel;
        res_en     <= en_sel;
        dur        <= en_sel - st_sel;
      end else begin
        res_status <= hit ? ST_DUP : (have_free ? ST_STORED : ST_FULL);
        res_st     <= '0;
        res_en     <= '0;
      end
    end
    if (cmd.stat_wr) begin
      res_cnt <= new_cnt;
      res_tot <= new_tot;
    end
    if (cmd.drain_step && drain_done) begin
      res_status <= ST_DONE;
      res_uid    <= '0;
      res_type   <= '0;
      res_extra  <= '0;
      res_st     <= '0;
      res_en     <= '0;
      res_cnt    <= '0;
      res_tot    <= '0;
    end
    if (cmd.drain_wr) begin
      res_status <= ST_RECORD;
      res_uid    <= rec_id;
      res_type   <= 8'(cursor);
      res_extra  <= '0;
      res_st     <= min_seen;
      res_en     <= max_seen;
      res_cnt    <= s_rdata[95:64];
      res_tot    <= s_rdata[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      pair_id     <= res_uid;
      type_id     <= res_type;
      extra_info  <= res_extra;
      t_start     <= res_st;
      t_end       <= res_en;
      event_count <= res_cnt;
      dur_total   <= res_tot;
    end
  end

endmodule

// ----- design/trace_event_pair_matcher.sv -----
// Top level of the trace event pair matcher.
`timescale 1ns / 1ps
// Matches start and end trace events by id through a pending table and reports
// pairs or per-type statistics, one result per input transaction. After reset
// the block clears its pending table before taking the first transaction. A
// trace event is handled by a linear scan of the pending table memory at one
// entry per cycle, plus a statistics read and write in statistics mode; a zero
// word needs no scan. A drain transaction steps the cursor over the touched
// flags one type per cycle. The result waits in an output register while the
// next transaction is taken; a transaction whose result finds that register
// still full stalls until it is taken.
module trace_event_pair_matcher #(
  parameter int PENDING_DEPTH = 256,
  parameter int NUM_TYPES     = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        stats_mode_wr_en,
  input  logic        stats_mode_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [63:0] event_word,
  input  logic [63:0] timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] pair_id,
  output logic [7:0]  type_id,
  output logic [15:0] extra_info,
  output logic [63:0] t_start,
  output logic [63:0] t_end,
  output logic [31:0] event_count,
  output logic [63:0] dur_total
);
  import tepm_pkg::*;

  tepm_cmd_t  cmd;
  tepm_stat_t st;

  tepm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  tepm_dp #(.PENDING_DEPTH(PENDING_DEPTH), .NUM_TYPES(NUM_TYPES)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .stats_mode_wr_en  (stats_mode_wr_en),
    .stats_mode_wr_data(stats_mode_wr_data),
    .func              (func),
    .event_word        (event_word),
    .timestamp         (timestamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .pair_id           (pair_id),
    .type_id           (type_id),
    .extra_info        (extra_info),
    .t_start           (t_start),
    .t_end             (t_end),
    .event_count       (event_count),
    .dur_total         (dur_total)
  );

endmodule
